@@ sv/cdcw_pkg.sv @@
// Shared types, constants and helpers of the CAN drive command watchdog.
package cdcw_pkg;

  localparam int unsigned SERVO_CHANNELS_DEF = 8;
  localparam int unsigned MOTOR_CHANNELS_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  localparam int unsigned ID_W      = 11;
  localparam int unsigned DLC_W     = 4;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned PULSE_W   = 12;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned LED_W     = 2;
  localparam int unsigned AGE_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  localparam logic [ID_W-1:0]  ESTOP_ID    = 11'h000;
  localparam logic [ID_W-1:0]  RELEASE_ID  = 11'h001;
  localparam logic [DLC_W-1:0] RELEASE_DLC = 4'd3;
  localparam logic [DLC_W-1:0] MOTOR_DLC   = 4'd8;
  localparam logic [7:0]       REL_CHAR0   = 8'h63;
  localparam logic [7:0]       REL_CHAR1   = 8'h6c;
  localparam logic [7:0]       REL_CHAR2   = 8'h72;

  localparam logic [7:0]         SERVO_CODE_MAX = 8'd200;
  localparam logic [7:0]         SERVO_CODE_OFF = 8'd255;
  localparam logic [PULSE_W-1:0] PULSE_BASE_US  = 12'd500;
  localparam logic [PULSE_W-1:0] PULSE_STEP_US  = 12'd10;
  localparam logic [CHAN_W-1:0]  MOTOR_CHAN_BASE = 4'd8;
  localparam logic [AGE_W-1:0]   AGE_MAX        = 16'hffff;
  localparam logic [16:0]        DUTY_WRAP      = 17'h10000;
  localparam int unsigned        DUTY_SHIFT     = 15;

  localparam logic [ID_W-1:0]  SERVO_ID_RST = 11'd672;
  localparam logic [ID_W-1:0]  MOTOR_ID_RST = 11'd608;
  localparam logic [AGE_W-1:0] TIMEOUT_RST  = 16'd100;
  localparam logic [AGE_W-1:0] PWM_TOP_RST  = 16'd6649;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERVO_ID = 2'd0,
    REG_MOTOR_ID = 2'd1,
    REG_TIMEOUT  = 2'd2,
    REG_PWM_TOP  = 2'd3
  } cfg_reg_e;

  typedef enum logic [LED_W-1:0] {
    LED_IDLE   = 2'd0,
    LED_ACTIVE = 2'd1,
    LED_STOP   = 2'd2
  } led_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_STOP,
    OP_RELEASE,
    OP_SERVO,
    OP_MOTOR
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [PAYLOAD_W-1:0] payload;
  } cdcw_op_t;

  typedef struct packed {
    logic [ID_W-1:0]  servo_id;
    logic [ID_W-1:0]  motor_id;
    logic [AGE_W-1:0] timeout;
    logic [AGE_W-1:0] pwm_top;
  } cdcw_cfg_t;

  // Byte i of the payload, byte 0 being the most significant.
  function automatic logic [7:0] byte_at(logic [PAYLOAD_W-1:0] pl, int unsigned i);
    byte_at = pl[(7 - i) * 8 +: 8];
  endfunction

endpackage

@@ sv/cdcw_if.sv @@
// Valid/ready channel interfaces for frame/tick words and channel result words.
interface cdcw_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [10:0] frame_id;
  logic        extended;
  logic        remote;
  logic [3:0]  dlc;
  logic [63:0] payload;

  modport source (output valid, command, frame_id, extended, remote, dlc, payload,
                  input ready);
  modport sink (input valid, command, frame_id, extended, remote, dlc, payload,
                output ready);
endinterface

interface cdcw_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel;
  logic        channel_on;
  logic [11:0] servo_pulse_us;
  logic [15:0] motor_level;
  logic        motor_reverse;
  logic [1:0]  status_led;
  logic        estop_active;
  logic        last_of_run;

  modport source (output valid, channel, channel_on, servo_pulse_us, motor_level,
                  motor_reverse, status_led, estop_active, last_of_run,
                  input ready);
  modport sink (input valid, channel, channel_on, servo_pulse_us, motor_level,
                motor_reverse, status_led, estop_active, last_of_run,
                output ready);
endinterface

@@ sv/cdcw_queue.sv @@
// Small first-in first-out queue of decoded operations.
module cdcw_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end
endmodule

@@ sv/cdcw_front.sv @@
// Input side: accepts frame/tick words and decodes them into operations.
module cdcw_front #(
  parameter int unsigned SERVO_CHANNELS = 8
) (
  cdcw_in_if.sink               in_s,
  input  cdcw_pkg::cdcw_cfg_t   cfg_i,
  output logic                  op_valid_o,
  input  logic                  op_ready_i,
  output cdcw_pkg::cdcw_op_t    op_o
);
  import cdcw_pkg::*;

  logic servo_bytes_ok;
  logic release_ok;
  op_e  op;

  always_comb begin
    servo_bytes_ok = 1'b1;
    for (int unsigned i = 0; i < SERVO_CHANNELS; i++) begin
      if (byte_at(in_s.payload, i) > SERVO_CODE_MAX &&
          byte_at(in_s.payload, i) != SERVO_CODE_OFF) begin
        servo_bytes_ok = 1'b0;
      end
    end
  end

  assign release_ok = (in_s.dlc == RELEASE_DLC) &&
                      (byte_at(in_s.payload, 0) == REL_CHAR0) &&
                      (byte_at(in_s.payload, 1) == REL_CHAR1) &&
                      (byte_at(in_s.payload, 2) == REL_CHAR2);

  // Stop and release identifiers win over configured command identifiers.
  // A servo frame that fails its checks may still qualify as a motor frame.
  always_comb begin
    if (in_s.command) begin
      op = OP_TICK;
    end else if (in_s.extended || in_s.remote) begin
      op = OP_NONE;
    end else if (in_s.frame_id == ESTOP_ID) begin
      op = OP_STOP;
    end else if (in_s.frame_id == RELEASE_ID) begin
      op = release_ok ? OP_RELEASE : OP_NONE;
    end else if (in_s.frame_id == cfg_i.servo_id &&
                 in_s.dlc == DLC_W'(SERVO_CHANNELS) && servo_bytes_ok) begin
      op = OP_SERVO;
    end else if (in_s.frame_id == cfg_i.motor_id && in_s.dlc == MOTOR_DLC) begin
      op = OP_MOTOR;
    end else begin
      op = OP_NONE;
    end
  end

  assign in_s.ready     = op_ready_i;
  assign op_valid_o     = in_s.valid;
  assign op_o.op        = op;
  assign op_o.payload   = in_s.payload;
endmodule

@@ sv/cdcw_back.sv @@
// Output side: applies operations to the watchdog state and emits channel results.
module cdcw_back #(
  parameter int unsigned SERVO_CHANNELS = 8,
  parameter int unsigned MOTOR_CHANNELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdcw_pkg::cdcw_cfg_t cfg_i,
  input  logic                op_valid_i,
  output logic                op_ready_o,
  input  cdcw_pkg::cdcw_op_t  op_i,
  cdcw_out_if.source          out_s
);
  import cdcw_pkg::*;

  localparam int unsigned NCH   = SERVO_CHANNELS + MOTOR_CHANNELS;
  localparam int unsigned CNT_W = $clog2(NCH);
  localparam int unsigned SIW   = (SERVO_CHANNELS > 1) ? $clog2(SERVO_CHANNELS) : 1;
  localparam int unsigned MIW   = (MOTOR_CHANNELS > 1) ? $clog2(MOTOR_CHANNELS) : 1;

  typedef enum logic {ST_IDLE, ST_EMIT} state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  ch_q;
  logic              estop_q, servo_seen_q, motor_seen_q;
  logic [AGE_W-1:0]  servo_age_q, motor_age_q;
  logic [7:0]        slots_q  [SERVO_CHANNELS];
  logic [15:0]       duties_q [MOTOR_CHANNELS];

  logic              out_valid_q, out_valid_d;
  logic [CHAN_W-1:0] chan_q;
  logic              on_q, rev_q, estop_out_q, last_q;
  logic [PULSE_W-1:0] pulse_q;
  logic [LEVEL_W-1:0] level_q;
  led_e              led_q;

  logic              take_op, load, is_servo, last_ch;
  logic              sfresh, mfresh, s_on, m_on, m_neg;
  logic [SIW-1:0]    sidx;
  logic [MIW-1:0]    midx;
  logic [7:0]        code;
  logic [15:0]       duty;
  logic [16:0]       mag;
  logic [32:0]       prod;
  led_e              led;

  assign op_ready_o = (state_q == ST_IDLE);
  assign take_op    = op_valid_i && op_ready_o;
  assign load       = (state_q == ST_EMIT) && (!out_valid_q || out_s.ready);

  // The output word stays valid until taken unless a new one replaces it.
  assign out_valid_d = load || (out_valid_q && !out_s.ready);

  assign is_servo = (ch_q < CNT_W'(SERVO_CHANNELS));
  assign last_ch  = (ch_q == CNT_W'(NCH - 1));
  assign sidx     = SIW'(ch_q);
  assign midx     = MIW'(ch_q - CNT_W'(SERVO_CHANNELS));
  assign code     = slots_q[sidx];
  assign duty     = duties_q[midx];

  assign sfresh = servo_seen_q && (servo_age_q < cfg_i.timeout);
  assign mfresh = motor_seen_q && (motor_age_q < cfg_i.timeout);
  assign led    = estop_q ? LED_STOP : ((sfresh || mfresh) ? LED_ACTIVE : LED_IDLE);

  assign s_on  = !estop_q && sfresh && (code != SERVO_CODE_OFF);
  assign m_neg = duty[15];
  assign m_on  = !estop_q && mfresh && (duty != '0);
  assign mag   = m_neg ? (DUTY_WRAP - {1'b0, duty}) : {1'b0, duty};
  assign prod  = 33'(mag) * 33'(cfg_i.pwm_top);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ch_q         <= '0;
      estop_q      <= 1'b0;
      servo_seen_q <= 1'b0;
      motor_seen_q <= 1'b0;
      servo_age_q  <= '0;
      motor_age_q  <= '0;
      out_valid_q  <= 1'b0;
      chan_q       <= '0;
      on_q         <= 1'b0;
      pulse_q      <= '0;
      level_q      <= '0;
      rev_q        <= 1'b0;
      led_q        <= LED_IDLE;
      estop_out_q  <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (take_op) begin
            state_q <= ST_EMIT;
            ch_q    <= '0;
            case (op_i.op)
              OP_TICK: begin
                if (servo_age_q != AGE_MAX) servo_age_q <= servo_age_q + 1'b1;
                if (motor_age_q != AGE_MAX) motor_age_q <= motor_age_q + 1'b1;
              end
              OP_STOP: begin
                estop_q      <= 1'b1;
                servo_seen_q <= 1'b0;
                motor_seen_q <= 1'b0;
              end
              OP_RELEASE: begin
                estop_q      <= 1'b0;
                servo_seen_q <= 1'b0;
                motor_seen_q <= 1'b0;
              end
              OP_SERVO: begin
                if (!estop_q) begin
                  servo_age_q  <= '0;
                  servo_seen_q <= 1'b1;
                end
              end
              OP_MOTOR: begin
                if (!estop_q) begin
                  motor_age_q  <= '0;
                  motor_seen_q <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (load) begin
            last_q      <= last_ch;
            led_q       <= led;
            estop_out_q <= estop_q;
            if (is_servo) begin
              chan_q  <= CHAN_W'(ch_q);
              on_q    <= s_on;
              pulse_q <= s_on ? (PULSE_BASE_US + PULSE_STEP_US * PULSE_W'(code)) : '0;
              level_q <= '0;
              rev_q   <= 1'b0;
            end else begin
              chan_q  <= MOTOR_CHAN_BASE + CHAN_W'(ch_q - CNT_W'(SERVO_CHANNELS));
              on_q    <= m_on;
              pulse_q <= '0;
              level_q <= m_on ? prod[DUTY_SHIFT +: LEVEL_W] : '0;
              rev_q   <= m_on && m_neg;
            end
            if (last_ch) begin
              state_q <= ST_IDLE;
            end else begin
              ch_q <= ch_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Command stores hold no reset value; they are read only once written.
  always_ff @(posedge clk_i) begin
    if (take_op && !estop_q && op_i.op == OP_SERVO) begin
      for (int unsigned i = 0; i < SERVO_CHANNELS; i++) begin
        slots_q[i] <= byte_at(op_i.payload, i);
      end
    end
    if (take_op && !estop_q && op_i.op == OP_MOTOR) begin
      for (int unsigned i = 0; i < MOTOR_CHANNELS; i++) begin
        duties_q[i] <= {byte_at(op_i.payload, 2 * i), byte_at(op_i.payload, 2 * i + 1)};
      end
    end
  end

  assign out_s.valid          = out_valid_q;
  assign out_s.channel        = chan_q;
  assign out_s.channel_on     = on_q;
  assign out_s.servo_pulse_us = pulse_q;
  assign out_s.motor_level    = level_q;
  assign out_s.motor_reverse  = rev_q;
  assign out_s.status_led     = led_q;
  assign out_s.estop_active   = estop_out_q;
  assign out_s.last_of_run    = last_q;
endmodule

@@ sv/can_drive_command_watchdog.sv @@
// Top level of the CAN drive command watchdog: configuration registers and the two halves.
//
// Usage:
//   in_s carries one word per received standard CAN frame (command = 0) or per
//   one millisecond tick (command = 1). Extended and remote frames are dropped.
//   For every word, out_s delivers one result word per channel: the servo
//   channels first (channel 0 up), then the motor channels (channel 8 up), with
//   last_of_run set on the final word of the run.
//   The front half decodes each word into an operation combinationally and parks
//   it in a two-entry queue, so the sender is not held up while results drain.
//   The back half first applies an operation to the stop latch, the age
//   counters and the command stores, then emits its channel results one after
//   another, and takes no new operation until the run is out. The motor level
//   multiply sits in the per-channel step, right in front of the output register.
//   If the receiver stalls, the output register holds its word and the back
//   half waits; the queue keeps taking words until it is full.
//   Reset clears the stop latch, both seen flags and both ages and loads the
//   register defaults. The registers are written through cfg_we_i/cfg_idx_i/
//   cfg_data_i and should only change while no results are outstanding.
module can_drive_command_watchdog #(
  parameter int unsigned SERVO_CHANNELS = cdcw_pkg::SERVO_CHANNELS_DEF,
  parameter int unsigned MOTOR_CHANNELS = cdcw_pkg::MOTOR_CHANNELS_DEF,
  parameter int unsigned QUEUE_DEPTH    = cdcw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cdcw_in_if.sink                          in_s,
  cdcw_out_if.source                       out_s,
  input  logic                             cfg_we_i,
  input  logic [cdcw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cdcw_pkg::CFG_W-1:0]       cfg_data_i
);
  import cdcw_pkg::*;

  cdcw_cfg_t cfg_q;
  cdcw_op_t  front_op, back_op;
  logic      front_valid, front_ready, back_valid, back_ready;

  // Register writes: identifiers keep their low 11 bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_id <= SERVO_ID_RST;
      cfg_q.motor_id <= MOTOR_ID_RST;
      cfg_q.timeout  <= TIMEOUT_RST;
      cfg_q.pwm_top  <= PWM_TOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SERVO_ID: cfg_q.servo_id <= cfg_data_i[ID_W-1:0];
        REG_MOTOR_ID: cfg_q.motor_id <= cfg_data_i[ID_W-1:0];
        REG_TIMEOUT:  cfg_q.timeout  <= cfg_data_i[AGE_W-1:0];
        REG_PWM_TOP:  cfg_q.pwm_top  <= cfg_data_i[AGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cdcw_front #(
    .SERVO_CHANNELS (SERVO_CHANNELS)
  ) u_front (
    .in_s       (in_s),
    .cfg_i      (cfg_q),
    .op_valid_o (front_valid),
    .op_ready_i (front_ready),
    .op_o       (front_op)
  );

  cdcw_queue #(
    .WIDTH ($bits(cdcw_op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_op),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_op)
  );

  cdcw_back #(
    .SERVO_CHANNELS (SERVO_CHANNELS),
    .MOTOR_CHANNELS (MOTOR_CHANNELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (back_valid),
    .op_ready_o (back_ready),
    .op_i       (back_op),
    .out_s      (out_s)
  );
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the CAN drive command watchdog.
module testbench;
  import cdcw_pkg::*;

  // Channel counts of the default build; the servo frame must carry one byte per servo.
  localparam int unsigned SERVO_COUNT   = SERVO_CHANNELS_DEF;
  localparam int unsigned MOTOR_COUNT   = MOTOR_CHANNELS_DEF;
  localparam int unsigned CHANNEL_COUNT = SERVO_COUNT + MOTOR_COUNT;

  // One word is applied and then answered with one channel word per channel.
  localparam int unsigned WORD_LATENCY  = CHANNEL_COUNT + 1;
  localparam int unsigned RANDOM_WORDS  = 500;
  localparam int unsigned RANDOM_PHASES = 4;
  // The age test runs the commands past a short timeout and keeps ticking.
  localparam logic [AGE_W-1:0] AGE_TIMEOUT = 16'd3;
  localparam int unsigned AGE_TICKS     = 6;
  localparam longint unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned MAX_REPORTS   = 40;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [ID_W-1:0]      frame_id;
    logic                 extended;
    logic                 remote;
    logic [DLC_W-1:0]     dlc;
    logic [PAYLOAD_W-1:0] payload;
  } frame_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic               channel_on;
    logic [PULSE_W-1:0] servo_pulse_us;
    logic [LEVEL_W-1:0] motor_level;
    logic               motor_reverse;
    led_e               status_led;
    logic               estop_active;
    logic               last_of_run;
  } channel_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  cdcw_in_if  in_ch ();
  cdcw_out_if out_ch ();

  can_drive_command_watchdog dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_s      (in_ch),
    .out_s     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Our own copy of the block's registers and state. The register copy is
  // updated the moment a write is driven; writes only happen while idle.
  logic [ID_W-1:0]  servo_id_q;
  logic [ID_W-1:0]  motor_id_q;
  logic [AGE_W-1:0] timeout_q;
  logic [AGE_W-1:0] pwm_top_q;
  logic             stop_latched;
  logic             servo_seen;
  logic             motor_seen;
  logic [AGE_W-1:0] servo_age;
  logic [AGE_W-1:0] motor_age;
  logic [7:0]       servo_codes [SERVO_COUNT];
  logic [15:0]      motor_duties [MOTOR_COUNT];

  // Channel words still owed by the block, oldest first.
  channel_word_t pending_channels [$];

  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  longint unsigned cycle_count = 0;

  // Applies one accepted word to the state copy and queues the twelve
  // channel words the block must answer with.
  task automatic advance_watchdog(input frame_word_t w);
    logic          servo_ok;
    logic [7:0]    b;
    logic          sfresh;
    logic          mfresh;
    led_e          led;
    channel_word_t r;
    logic [15:0]   duty;
    logic [16:0]   mag;
    logic [32:0]   prod;
    if (w.command == CMD_TICK) begin
      if (servo_age != AGE_MAX) servo_age = servo_age + 1'b1;
      if (motor_age != AGE_MAX) motor_age = motor_age + 1'b1;
    end else if (!w.extended && !w.remote) begin
      // The stop and release identifiers win over any command identifier.
      if (w.frame_id == ESTOP_ID) begin
        stop_latched = 1'b1;
        servo_seen = 1'b0;
        motor_seen = 1'b0;
      end else if (w.frame_id == RELEASE_ID) begin
        if (w.dlc == RELEASE_DLC && w.payload[63:56] == REL_CHAR0 &&
            w.payload[55:48] == REL_CHAR1 && w.payload[47:40] == REL_CHAR2) begin
          stop_latched = 1'b0;
          servo_seen = 1'b0;
          motor_seen = 1'b0;
        end
      end else if (!stop_latched) begin
        // A servo frame with a bad code falls through to the motor check,
        // which matters when both identifiers are the same.
        servo_ok = 1'b0;
        if (w.frame_id == servo_id_q && w.dlc == SERVO_COUNT) begin
          servo_ok = 1'b1;
          for (int i = 0; i < SERVO_COUNT; i++) begin
            b = w.payload[(7 - i) * 8 +: 8];
            if (b > SERVO_CODE_MAX && b != SERVO_CODE_OFF) servo_ok = 1'b0;
          end
          if (servo_ok) begin
            for (int i = 0; i < SERVO_COUNT; i++) servo_codes[i] = w.payload[(7 - i) * 8 +: 8];
            servo_age = '0;
            servo_seen = 1'b1;
          end
        end
        if (!servo_ok && w.frame_id == motor_id_q && w.dlc == MOTOR_DLC) begin
          for (int m = 0; m < MOTOR_COUNT; m++) motor_duties[m] = w.payload[(3 - m) * 16 +: 16];
          motor_age = '0;
          motor_seen = 1'b1;
        end
      end
    end

    sfresh = servo_seen && (servo_age < timeout_q);
    mfresh = motor_seen && (motor_age < timeout_q);
    if (stop_latched) led = LED_STOP;
    else if (sfresh || mfresh) led = LED_ACTIVE;
    else led = LED_IDLE;

    for (int i = 0; i < SERVO_COUNT; i++) begin
      r = '0;
      r.channel = CHAN_W'(i);
      r.channel_on = !stop_latched && sfresh && servo_codes[i] != SERVO_CODE_OFF;
      if (r.channel_on) r.servo_pulse_us = PULSE_BASE_US + PULSE_STEP_US * PULSE_W'(servo_codes[i]);
      r.status_led = led;
      r.estop_active = stop_latched;
      pending_channels.push_back(r);
    end
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      r = '0;
      duty = motor_duties[m];
      mag = duty[15] ? (DUTY_WRAP - {1'b0, duty}) : {1'b0, duty};
      prod = 33'(mag) * 33'(pwm_top_q);
      r.channel = MOTOR_CHAN_BASE + CHAN_W'(m);
      r.channel_on = !stop_latched && mfresh && duty != 16'h0000;
      if (r.channel_on) begin
        r.motor_level = prod[DUTY_SHIFT +: LEVEL_W];
        r.motor_reverse = duty[15];
      end
      r.status_led = led;
      r.estop_active = stop_latched;
      r.last_of_run = (m == MOTOR_COUNT - 1);
      pending_channels.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Every channel word taken from the block is held against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    channel_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_channels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $error("channel word with no expectation waiting");
      end else begin
        want = pending_channels.pop_front();
        check_field("channel", want.channel, out_ch.channel);
        check_field("channel_on", want.channel_on, out_ch.channel_on);
        check_field("servo_pulse_us", want.servo_pulse_us, out_ch.servo_pulse_us);
        check_field("motor_level", want.motor_level, out_ch.motor_level);
        check_field("motor_reverse", want.motor_reverse, out_ch.motor_reverse);
        check_field("status_led", want.status_led, out_ch.status_led);
        check_field("estop_active", want.estop_active, out_ch.estop_active);
        check_field("last_of_run", want.last_of_run, out_ch.last_of_run);
      end
    end
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // A hung block ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Called and returning at a falling edge. Valid stays high after the
  // word is taken; the next call either reuses it or drops it for a gap,
  // so valid never sees two assignments in one step.
  task automatic send_word(input frame_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= w.command;
    in_ch.frame_id <= w.frame_id;
    in_ch.extended <= w.extended;
    in_ch.remote   <= w.remote;
    in_ch.dlc      <= w.dlc;
    in_ch.payload  <= w.payload;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    advance_watchdog(w);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every owed channel word has come out.
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (pending_channels.size() != 0) @(negedge clk_i);
  endtask

  // Every word yields results, so the block is idle once the last one is
  // out; the extra wait only gives the output register time to clear.
  task automatic settle();
    wait_results_done();
    repeat (4) @(negedge clk_i);
  endtask

  // One register write, followed by a quiet spell with the enable low, so the
  // enable is never dropped and raised in the same step.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      REG_SERVO_ID: servo_id_q = value[ID_W-1:0];
      REG_MOTOR_ID: motor_id_q = value[ID_W-1:0];
      REG_TIMEOUT:  timeout_q  = value;
      REG_PWM_TOP:  pwm_top_q  = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_all_regs(input logic [ID_W-1:0] servo_id, input logic [ID_W-1:0] motor_id,
                                input logic [AGE_W-1:0] timeout, input logic [AGE_W-1:0] top);
    write_reg(REG_SERVO_ID, CFG_W'(servo_id));
    write_reg(REG_MOTOR_ID, CFG_W'(motor_id));
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_PWM_TOP, top);
  endtask

  function automatic frame_word_t frame(input logic [ID_W-1:0] id, input logic [DLC_W-1:0] dlc,
                                        input logic [PAYLOAD_W-1:0] payload);
    frame_word_t w;
    w = '0;
    w.command = CMD_FRAME;
    w.frame_id = id;
    w.dlc = dlc;
    w.payload = payload;
    return w;
  endfunction

  function automatic frame_word_t tick_word();
    frame_word_t w;
    w = '0;
    w.command = CMD_TICK;
    return w;
  endfunction

  // Mostly well-formed commands with random content, plus stop and release
  // traffic, ticks and pure noise.
  function automatic frame_word_t random_word();
    frame_word_t w;
    int unsigned pick;
    logic [7:0] code;
    logic [15:0] duty;
    w.command  = CMD_FRAME;
    w.frame_id = ID_W'($urandom_range(2047));
    w.extended = ($urandom_range(29) == 0);
    w.remote   = ($urandom_range(29) == 0);
    w.dlc      = DLC_W'($urandom_range(15));
    w.payload  = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 18) begin
      // Ticks carry random frame fields, which the block must not look at.
      w.command = CMD_TICK;
    end else if (pick < 48) begin
      w.frame_id = servo_id_q;
      w.dlc = DLC_W'(SERVO_COUNT);
      for (int i = 0; i < SERVO_COUNT; i++) begin
        case ($urandom_range(7))
          0: code = 8'd0;
          1: code = SERVO_CODE_MAX;
          2: code = SERVO_CODE_OFF;
          default: code = 8'($urandom_range(SERVO_CODE_MAX));
        endcase
        w.payload[(7 - i) * 8 +: 8] = code;
      end
      if ($urandom_range(9) == 0)
        w.payload[$urandom_range(7) * 8 +: 8] = 8'($urandom_range(201, 254));
    end else if (pick < 73) begin
      w.frame_id = motor_id_q;
      w.dlc = MOTOR_DLC;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        case ($urandom_range(7))
          0: duty = 16'h0000;
          1: duty = 16'h8000;
          2: duty = 16'h7fff;
          3: duty = 16'hffff;
          default: duty = 16'($urandom);
        endcase
        w.payload[(3 - m) * 16 +: 16] = duty;
      end
    end else if (pick < 76) begin
      w.frame_id = ESTOP_ID;
    end else if (pick < 84) begin
      w.frame_id = RELEASE_ID;
      w.dlc = RELEASE_DLC;
      w.payload[63:40] = {REL_CHAR0, REL_CHAR1, REL_CHAR2};
      // A quarter of the releases are broken in length or in one byte.
      case ($urandom_range(7))
        0: w.dlc = DLC_W'($urandom_range(15));
        1: w.payload[$urandom_range(5, 7) * 8 +: 8] = 8'($urandom);
        default: ;
      endcase
    end
    return w;
  endfunction

  // Every opcode path and decode corner at the reset register values.
  task automatic test_frame_decode();
    frame_word_t w;
    send_word(tick_word());
    send_word(frame(SERVO_ID_RST, 4'd8, 64'h00_c8_ff_64_01_c7_32_ff));
    send_word(frame(MOTOR_ID_RST, MOTOR_DLC, 64'h7fff_8000_0000_ffff));
    // Codes between the largest pulse and the off code reject the frame.
    send_word(frame(SERVO_ID_RST, 4'd8, 64'h10_20_c9_00_00_00_00_00));
    send_word(frame(SERVO_ID_RST, 4'd8, 64'h00_00_00_00_00_00_00_fe));
    send_word(frame(SERVO_ID_RST, 4'd7, 64'h05_05_05_05_05_05_05_05));
    send_word(frame(MOTOR_ID_RST, 4'd15, 64'hffff_ffff_ffff_ffff));
    w = frame(SERVO_ID_RST, 4'd8, 64'h0a_0a_0a_0a_0a_0a_0a_0a);
    w.extended = 1'b1;
    send_word(w);
    w = frame(MOTOR_ID_RST, MOTOR_DLC, 64'h1234_1234_1234_1234);
    w.remote = 1'b1;
    send_word(w);
    send_word(frame(RELEASE_ID, 4'd4, {REL_CHAR0, REL_CHAR1, REL_CHAR2, 40'h0}));
    send_word(frame(RELEASE_ID, RELEASE_DLC, {REL_CHAR0, REL_CHAR1, 8'h73, 40'h0}));
    // The stop frame latches with any length.
    send_word(frame(ESTOP_ID, 4'd15, 64'hffff_ffff_ffff_ffff));
    send_word(frame(SERVO_ID_RST, 4'd8, 64'h01_02_03_04_05_06_07_08));
    send_word(frame(RELEASE_ID, RELEASE_DLC, {REL_CHAR0, REL_CHAR1, REL_CHAR2, 40'hff_ffff_ffff}));
    w = frame(ESTOP_ID, 4'd0, 64'h0);
    w.extended = 1'b1;
    send_word(w);
    send_word(frame(MOTOR_ID_RST, MOTOR_DLC, 64'h0001_8001_4000_c000));
    settle();
  endtask

  // Register extremes: command identifiers on top of stop and release,
  // both command identifiers equal, a timeout of 1, PWM tops of 16'hffff and 1.
  task automatic test_register_extremes();
    write_all_regs(ESTOP_ID, RELEASE_ID, 16'd1, 16'hffff);
    send_word(frame(ESTOP_ID, 4'd8, 64'h00_c8_ff_64_01_c7_32_ff));
    send_word(frame(RELEASE_ID, MOTOR_DLC, 64'h7fff_8000_0001_ffff));
    send_word(frame(RELEASE_ID, RELEASE_DLC, {REL_CHAR0, REL_CHAR1, REL_CHAR2, 40'h0}));
    settle();
    write_reg(REG_SERVO_ID, CFG_W'(11'h7ff));
    write_reg(REG_MOTOR_ID, CFG_W'(11'h7ff));
    send_word(frame(11'h7ff, 4'd8, 64'h00_c8_ff_64_01_c7_32_ff));
    // A frame whose bytes are all valid servo codes is a servo command, not a motor one.
    send_word(frame(11'h7ff, 4'd8, 64'h7fff_8000_0001_ffff));
    send_word(tick_word());
    send_word(frame(11'h7ff, 4'd8, 64'h7fff_8000_0001_ffff));
    settle();
    write_reg(REG_PWM_TOP, 16'd1);
    send_word(frame(11'h7ff, 4'd8, 64'h8000_7fff_0001_ffff));
    settle();
  endtask

  // A command is fresh while its age is below the timeout and goes stale
  // exactly when the age reaches it; a new motor command restarts only
  // the motor age, so the two kinds go stale on different ticks.
  task automatic test_age_timeout();
    write_all_regs(SERVO_ID_RST, MOTOR_ID_RST, AGE_TIMEOUT, PWM_TOP_RST);
    send_word(frame(SERVO_ID_RST, 4'd8, 64'h64_64_64_64_64_64_64_64));
    send_word(frame(MOTOR_ID_RST, MOTOR_DLC, 64'h4000_c000_0100_ff00));
    for (int n = 0; n < AGE_TICKS; n++) begin
      send_word(tick_word());
      if (n == 1) send_word(frame(MOTOR_ID_RST, MOTOR_DLC, 64'hc000_4000_ff00_0100));
    end
    settle();
  endtask

  // Random traffic in phases that each set their own registers and their
  // own sender and receiver idling.
  task automatic test_random_traffic();
    logic [ID_W-1:0] shared_id;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          write_all_regs(SERVO_ID_RST, MOTOR_ID_RST, TIMEOUT_RST, PWM_TOP_RST);
          send_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          write_all_regs(ID_W'($urandom_range(2, 2047)), ID_W'($urandom_range(2, 2047)),
                         16'd4, 16'($urandom_range(1, 65535)));
          send_idle_pct = 55;
          sink_stall_pct = 0;
        end
        2: begin
          shared_id = ID_W'($urandom_range(2, 2047));
          write_all_regs(shared_id, shared_id, 16'd2, 16'd1);
          send_idle_pct = 0;
          sink_stall_pct = 55;
        end
        default: begin
          write_all_regs(11'h7ff, 11'd2, 16'hffff, 16'hffff);
          send_idle_pct = 8;
          sink_stall_pct = 8;
        end
      endcase
      for (int n = 0; n < RANDOM_WORDS / RANDOM_PHASES; n++) begin
        send_word(random_word());
        // Now and then the sender waits for the block to drain completely.
        if ($urandom_range(39) == 0) wait_results_done();
      end
    end
    send_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_SERVO_ID;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_FRAME;
    in_ch.frame_id = '0;
    in_ch.extended = 1'b0;
    in_ch.remote = 1'b0;
    in_ch.dlc = '0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;

    servo_id_q = SERVO_ID_RST;
    motor_id_q = MOTOR_ID_RST;
    timeout_q = TIMEOUT_RST;
    pwm_top_q = PWM_TOP_RST;
    stop_latched = 1'b0;
    servo_seen = 1'b0;
    motor_seen = 1'b0;
    servo_age = '0;
    motor_age = '0;
    for (int i = 0; i < SERVO_COUNT; i++) servo_codes[i] = '0;
    for (int m = 0; m < MOTOR_COUNT; m++) motor_duties[m] = '0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_frame_decode();
    test_register_extremes();
    test_age_timeout();
    test_random_traffic();

    // Let anything stray show up before the verdict.
    wait_results_done();
    repeat (2 * WORD_LATENCY) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
